@@ sv/tgarle_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA run-length stream decoder package
// Shared types and constants of the parser and the result queue.
// ----------------------------------------------------------------------------
package tgarle_pkg;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_WAIT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_PACKET = 2'd2,
    PH_PIXEL  = 2'd3
  } phase_e;

  // Result kinds.
  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_SPAN     = 3'd1,
    KIND_FINAL    = 3'd2,
    KIND_BAD_TYPE = 3'd3,
    KIND_BAD_SIZE = 3'd4,
    KIND_OVERRUN  = 3'd5,
    KIND_TRUNC    = 3'd6
  } kind_e;

  // Header byte positions.
  localparam logic [4:0] HdrFixedLen = 5'd12;
  localparam logic [4:0] HdrTypeIdx  = 5'd2;
  localparam logic [4:0] HdrWidthLo  = 5'd12;
  localparam logic [4:0] HdrWidthHi  = 5'd13;
  localparam logic [4:0] HdrHeightLo = 5'd14;
  localparam logic [4:0] HdrHeightHi = 5'd15;
  localparam logic [4:0] HdrDepth    = 5'd16;

  // Header byte values.
  localparam logic [7:0] TypeRaw  = 8'd2;
  localparam logic [7:0] TypeRle  = 8'd10;
  localparam logic [7:0] Depth24  = 8'd24;
  localparam logic [7:0] Depth32  = 8'd32;
  localparam logic [7:0] RunBias  = 8'd127;

  // Descriptor flag bit positions.
  localparam int unsigned DescVertBit  = 5;
  localparam int unsigned DescHorizBit = 4;

  // Width of the packed result data word, filled up to whole bytes.
  localparam int unsigned ResDataBits = 107;
  localparam int unsigned ResDataPad  = 112;

  // One result item.
  typedef struct packed {
    kind_e       kind;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic        has_alpha;
    logic        flip_vertical;
    logic        flip_horizontal;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic [7:0]  alpha;
    logic [7:0]  span_count;
    logic [31:0] first_pixel;
  } result_t;

  // Results that one byte produces, handed to the result queue.
  typedef struct packed {
    logic [1:0] count;
    result_t    res0;
    result_t    res1;
  } result_pair_t;

endpackage

@@ sv/tgarle_parser.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA parser
// Holds the file parsing state and turns one file byte into up to two results.
// ----------------------------------------------------------------------------
module tgarle_parser
  import tgarle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  logic [7:0]   data_byte_i,
  input  logic         file_start_i,
  input  logic         file_end_i,
  output result_pair_t results_o
);

  phase_e      phase_q, phase_d;
  logic [4:0]  idx_q, idx_d;
  logic        is_rle_q, is_rle_d;
  logic [15:0] width_q, width_d;
  logic [15:0] height_q, height_d;
  logic        four_q, four_d;
  logic [31:0] done_q, done_d;
  logic [31:0] left_q, left_d;
  logic [7:0]  rem_q, rem_d;
  logic        run_q, run_d;
  logic [23:0] colour_q, colour_d;
  logic [1:0]  col_idx_q, col_idx_d;

  phase_e      phase_eff;
  logic [4:0]  idx_eff;
  logic        hdr_ok;
  logic [7:0]  pkt_count;
  logic [7:0]  span_count;
  logic [1:0]  last_idx;
  result_pair_t res;

  // Packet header count: raw packets carry count-1, run packets count+127.
  assign pkt_count  = data_byte_i[7] ? (data_byte_i - RunBias) : (data_byte_i + 8'd1);
  assign span_count = (is_rle_q && run_q) ? rem_q : 8'd1;
  assign last_idx   = four_q ? 2'd3 : 2'd2;

  // A start byte restarts the header in any phase.
  assign phase_eff = file_start_i ? PH_HEADER : phase_q;
  assign idx_eff   = file_start_i ? 5'd0 : idx_q;

  // Next state and results of the current byte.
  always_comb begin
    phase_d   = phase_q;
    idx_d     = idx_q;
    is_rle_d  = is_rle_q;
    width_d   = width_q;
    height_d  = height_q;
    four_d    = four_q;
    done_d    = done_q;
    left_d    = left_q;
    rem_d     = rem_q;
    run_d     = run_q;
    colour_d  = colour_q;
    col_idx_d = col_idx_q;
    hdr_ok    = 1'b1;
    res       = '0;

    if (fire_i && (phase_eff != PH_WAIT)) begin
      phase_d = phase_eff;
      idx_d   = idx_eff;
      case (phase_eff)
        PH_HEADER: begin
          if (idx_eff < HdrFixedLen) begin
            if (idx_eff == HdrTypeIdx) begin
              hdr_ok   = data_byte_i inside {TypeRaw, TypeRle};
              is_rle_d = (data_byte_i == TypeRle);
            end else begin
              hdr_ok = (data_byte_i == 8'd0);
            end
            if (!hdr_ok) begin
              res.count     = 2'd1;
              res.res0.kind = KIND_BAD_TYPE;
              phase_d       = PH_WAIT;
            end else begin
              idx_d = idx_eff + 5'd1;
            end
          end else begin
            case (idx_eff)
              HdrWidthLo: begin
                width_d = {8'd0, data_byte_i};
                idx_d   = idx_eff + 5'd1;
              end
              HdrWidthHi: begin
                width_d = {data_byte_i, width_q[7:0]};
                idx_d   = idx_eff + 5'd1;
              end
              HdrHeightLo: begin
                height_d = {8'd0, data_byte_i};
                idx_d    = idx_eff + 5'd1;
              end
              HdrHeightHi: begin
                height_d = {data_byte_i, height_q[7:0]};
                idx_d    = idx_eff + 5'd1;
              end
              HdrDepth: begin
                if ((width_q == 16'd0) || (height_q == 16'd0) ||
                    !(data_byte_i inside {Depth24, Depth32})) begin
                  res.count     = 2'd1;
                  res.res0.kind = KIND_BAD_SIZE;
                  phase_d       = PH_WAIT;
                end else begin
                  four_d = (data_byte_i == Depth32);
                  idx_d  = idx_eff + 5'd1;
                end
              end
              default: begin
                // Descriptor byte: the header is complete.
                left_d    = {16'd0, width_q} * {16'd0, height_q};
                done_d    = 32'd0;
                rem_d     = 8'd0;
                run_d     = 1'b0;
                col_idx_d = 2'd0;
                res.count = 2'd1;
                res.res0.kind            = KIND_HEADER;
                res.res0.image_width     = width_q;
                res.res0.image_height    = height_q;
                res.res0.has_alpha       = four_q;
                res.res0.flip_vertical   = data_byte_i[DescVertBit];
                res.res0.flip_horizontal = data_byte_i[DescHorizBit];
                phase_d = is_rle_q ? PH_PACKET : PH_PIXEL;
              end
            endcase
          end
        end
        PH_PACKET: begin
          run_d = data_byte_i[7];
          if ({24'd0, pkt_count} > left_q) begin
            res.count     = 2'd1;
            res.res0.kind = KIND_OVERRUN;
            phase_d       = PH_WAIT;
          end else begin
            rem_d     = pkt_count;
            col_idx_d = 2'd0;
            phase_d   = PH_PIXEL;
          end
        end
        PH_PIXEL: begin
          if (col_idx_q < last_idx) begin
            // Collect colour bytes until the last byte of the pixel.
            case (col_idx_q)
              2'd0:    colour_d[7:0]   = data_byte_i;
              2'd1:    colour_d[15:8]  = data_byte_i;
              default: colour_d[23:16] = data_byte_i;
            endcase
            col_idx_d = col_idx_q + 2'd1;
          end else begin
            res.count            = 2'd1;
            res.res0.kind        = KIND_SPAN;
            res.res0.blue        = colour_q[7:0];
            res.res0.green       = colour_q[15:8];
            res.res0.red         = four_q ? colour_q[23:16] : data_byte_i;
            res.res0.alpha       = four_q ? data_byte_i : 8'd0;
            res.res0.span_count  = span_count;
            res.res0.first_pixel = done_q;
            done_d    = done_q + {24'd0, span_count};
            left_d    = left_q - {24'd0, span_count};
            col_idx_d = 2'd0;
            if ({24'd0, span_count} >= left_q) begin
              res.res0.kind = KIND_FINAL;
              phase_d       = PH_WAIT;
            end else if (is_rle_q) begin
              if (run_q) begin
                phase_d = PH_PACKET;
              end else begin
                rem_d = rem_q - 8'd1;
                if (rem_q == 8'd1) begin
                  phase_d = PH_PACKET;
                end
              end
            end
          end
        end
        default: begin
        end
      endcase

      // A file that ends while still being parsed is reported truncated.
      if (file_end_i && (phase_d != PH_WAIT)) begin
        if (res.count == 2'd0) begin
          res.count     = 2'd1;
          res.res0.kind = KIND_TRUNC;
        end else begin
          res.count     = 2'd2;
          res.res1.kind = KIND_TRUNC;
        end
        phase_d = PH_WAIT;
      end
    end
  end

  assign results_o = res;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_WAIT;
      idx_q     <= 5'd0;
      is_rle_q  <= 1'b0;
      width_q   <= 16'd0;
      height_q  <= 16'd0;
      four_q    <= 1'b0;
      done_q    <= 32'd0;
      left_q    <= 32'd0;
      rem_q     <= 8'd0;
      run_q     <= 1'b0;
      colour_q  <= 24'd0;
      col_idx_q <= 2'd0;
    end else begin
      phase_q   <= phase_d;
      idx_q     <= idx_d;
      is_rle_q  <= is_rle_d;
      width_q   <= width_d;
      height_q  <= height_d;
      four_q    <= four_d;
      done_q    <= done_d;
      left_q    <= left_d;
      rem_q     <= rem_d;
      run_q     <= run_d;
      colour_q  <= colour_d;
      col_idx_q <= col_idx_d;
    end
  end

endmodule

@@ sv/tgarle_res_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA result queue
// Four-entry register queue that takes up to two results a cycle and gives
// one result per request on the output side.
// ----------------------------------------------------------------------------
module tgarle_res_fifo
  import tgarle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  result_pair_t push_i,
  output logic         room_o,
  output logic         valid_o,
  input  logic         ready_i,
  output result_t      data_o
);

  localparam int unsigned Depth   = 4;
  localparam int unsigned PtrBits = $clog2(Depth);
  localparam int unsigned CntBits = $clog2(Depth + 1);

  result_t              mem_q [Depth];
  logic [PtrBits-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrBits-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntBits-1:0]   cnt_q, cnt_d;
  logic                 pop;
  logic [PtrBits-1:0]   wr_ptr_nxt;

  // Room for the two results that one byte may produce.
  assign room_o     = (cnt_q <= CntBits'(Depth - 2));
  assign valid_o    = (cnt_q != '0);
  assign data_o     = mem_q[rd_ptr_q];
  assign pop        = valid_o && ready_i;
  assign wr_ptr_nxt = wr_ptr_q + PtrBits'(1);

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrBits'(push_i.count);
    rd_ptr_d = pop ? (rd_ptr_q + PtrBits'(1)) : rd_ptr_q;
    cnt_d    = cnt_q + CntBits'(push_i.count) - CntBits'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // Result storage.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.res0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nxt] <= push_i.res1;
    end
  end

endmodule

@@ sv/tga_rle_stream_decoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TGA run-length stream decoder
// Parses a TGA file (type 2 or type 10) byte by byte into header, pixel span
// and error results.
// ----------------------------------------------------------------------------
// The decoder takes one file byte per clock cycle while the result queue has
// room. A byte is held in an input register, decoded combinationally by the
// parser and its results (none, one or two) are placed in a four-entry
// result queue, which registers them for output. The input only stalls when the
// result queue holds more than two results, which happens only when the
// output side is held off. A byte flagged as file start (tuser) restarts
// parsing; the header result follows the eighteenth byte.
// Spans with a count above one stand for a run of identical pixels that a
// downstream memory writer expands. Truncation is reported after the byte
// flagged tlast if the file is still incomplete there.
// ----------------------------------------------------------------------------
module tga_rle_stream_decoder
  import tgarle_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [7:0]   s_axis_tdata_i,  // [7:0] data_byte
  input  logic [0:0]   s_axis_tuser_i,  // [0] file_start
  input  logic         s_axis_tlast_i,  // file_end
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // [15:0] image_width, [31:16] image_height, [32] has_alpha,
  // [33] flip_vertical, [34] flip_horizontal, [42:35] blue, [50:43] green,
  // [58:51] red, [66:59] alpha, [74:67] span_count, [106:75] first_pixel,
  // [111:107] zero
  output logic [111:0] m_axis_tdata_o,
  output logic [2:0]   m_axis_tuser_o   // [2:0] kind
);

  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  logic         in_start_q;
  logic         in_end_q;
  logic         room;
  logic         proc_fire;
  logic         in_take;
  result_pair_t results;
  result_t      res_out;

  // A held byte is decoded as soon as the queue has room for its results.
  assign proc_fire       = in_valid_q && room;
  assign s_axis_tready_o = !in_valid_q || proc_fire;
  assign in_take         = s_axis_tvalid_i && s_axis_tready_o;

  // Input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_byte_q  <= s_axis_tdata_i;
      in_start_q <= s_axis_tuser_i[0];
      in_end_q   <= s_axis_tlast_i;
    end
  end

  // Byte decoding.
  tgarle_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fire_i       (proc_fire),
    .data_byte_i  (in_byte_q),
    .file_start_i (in_start_q),
    .file_end_i   (in_end_q),
    .results_o    (results)
  );

  // Result queue.
  tgarle_res_fifo u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (results),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .data_o  (res_out)
  );

  // Output packing, lowest field first.
  assign m_axis_tuser_o = res_out.kind;
  assign m_axis_tdata_o = {
    (ResDataPad - ResDataBits)'(0),
    res_out.first_pixel,
    res_out.span_count,
    res_out.alpha,
    res_out.red,
    res_out.green,
    res_out.blue,
    res_out.flip_horizontal,
    res_out.flip_vertical,
    res_out.has_alpha,
    res_out.image_height,
    res_out.image_width
  };

endmodule
